/* rtl/vagg_pkg.sv */
package vagg_pkg;

  localparam logic [1:0] OP_VOTE = 2'd0;
  localparam logic [1:0] OP_SET  = 2'd1;
  localparam logic [1:0] OP_CLR  = 2'd2;
  localparam logic [1:0] OP_READ = 2'd3;

  localparam logic [1:0] VT_MIN  = 2'd0;
  localparam logic [1:0] VT_MAX  = 2'd1;
  localparam logic [1:0] VT_ANY  = 2'd2;
  localparam logic [1:0] VT_NONE = 2'd3;

  localparam logic [4:0] NO_CLIENT = 5'd16;

  typedef struct packed {
    logic        en;
    logic [31:0] val;
  } vote_t;

  typedef struct packed {
    logic        ok;
    logic [31:0] val;
    logic [4:0]  who;
  } elect_t;

endpackage

/* rtl/vote_aggregator_min_max_any.sv */
// Vote aggregator: one vote (enabled flag, signed value) per client slot, and
// an elected result over the enabled votes (minimum, maximum or any enabled).
// Input channel in_valid/in_ready carries op, client, enabled, value; output
// channel out_valid/out_ready carries one result item per input item.
// cfg_we/cfg_data write the election rule; write only while the block is idle.
// A cast vote that triggers an election passes through S_READ, S_SCAN,
// S_ELECT and S_DONE; S_SCAN reads the vote memory one entry per cycle
// through its single read port, whose read data is registered.
// A repeated vote, an ignored vote and the override and read ops go from
// S_READ straight to S_DONE.
// One item is in work at a time; the next item
// is accepted as soon as the previous one has been placed in the output
// register, even if that result is still waiting. When the receiver stalls
// with a result held, the following item stops before its result is loaded
// and in_ready stays low.
// Reset (rst, synchronous) clears all votes to zero through per-slot valid
// bits, drops any override and forgets the elected result; no clearing pass.
module vote_aggregator_min_max_any
  import vagg_pkg::*;
#(
  parameter int NUM_CLIENTS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         op,
  input  logic [3:0]         client,
  input  logic               enabled,
  input  logic signed [31:0] value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               notify,
  output logic               notify_has_value,
  output logic signed [31:0] notify_value,
  output logic [4:0]         notify_client,
  output logic               effective_valid,
  output logic signed [31:0] effective_value,
  output logic [4:0]         effective_client,
  output logic               override_active,
  output logic               client_enabled,
  output logic               client_value_valid,
  output logic signed [31:0] client_value
);

  localparam int IDX_W = $clog2(NUM_CLIENTS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_SCAN,
    S_ELECT,
    S_DONE
  } state_t;

  state_t           state;
  logic [1:0]       elect_mode;
  logic [1:0]       op_r;
  logic [3:0]       client_r;
  logic             en_r;
  logic [31:0]      value_r;
  logic             in_range_r;
  logic [IDX_W-1:0] idx_r;
  logic             cur_en;
  logic [31:0]      cur_val;
  logic             n_r;
  logic             nh_r;
  logic [31:0]      nv_r;
  logic [4:0]       nc_r;
  logic             elected_valid;
  logic [31:0]      elected_value;
  logic [4:0]       elected_client;
  logic             has_voted;
  logic             forced_active;
  logic [31:0]      forced_value;
  logic [IDX_W:0]   scan_cnt;
  logic             p_valid;
  logic [IDX_W-1:0] p_idx;

  logic [6:0]       client_ext;
  logic             in_range;
  logic             issuing;
  logic [IDX_W-1:0] raddr;
  logic             mem_we;
  vote_t            wdata;
  vote_t            rdata;
  elect_t           res;
  logic             elect_clear;
  logic             vote_ok;
  logic [31:0]      new_val;
  logic             same;
  logic [4:0]       who;
  logic             changed;

  assign client_ext   = {3'b0, client};
  assign in_range     = client_ext < 7'(NUM_CLIENTS);
  assign in_ready     = (state == S_IDLE);
  assign issuing      = (state == S_SCAN) && (scan_cnt != (IDX_W+1)'(NUM_CLIENTS));

  always_comb begin
    raddr = '0;
    if (state == S_IDLE && in_range) begin
      raddr = client_ext[IDX_W-1:0];
    end else if (issuing) begin
      raddr = scan_cnt[IDX_W-1:0];
    end
  end

  assign vote_ok  = (op_r == OP_VOTE) && (elect_mode != VT_NONE) && in_range_r;
  assign new_val  = (elect_mode == VT_ANY) ? {31'b0, en_r} : value_r;
  assign same     = (rdata.en == en_r) && (rdata.val == new_val);
  assign mem_we   = (state == S_READ) && vote_ok;
  assign wdata.en  = en_r;
  assign wdata.val = new_val;
  assign elect_clear = (state == S_READ);

  assign who     = (elect_mode == VT_ANY) ? {1'b0, client_r} : res.who;
  assign changed = !has_voted || (res.ok != elected_valid) || (res.val != elected_value);

  vagg_vote_mem #(
    .NUM_CLIENTS(NUM_CLIENTS)
  ) u_mem (
    .clk  (clk),
    .rst  (rst),
    .we   (mem_we),
    .waddr(idx_r),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  vagg_elect #(
    .NUM_CLIENTS(NUM_CLIENTS)
  ) u_elect (
    .clk       (clk),
    .rst       (rst),
    .clear     (elect_clear),
    .ent_valid (p_valid),
    .ent       (rdata),
    .ent_idx   (p_idx),
    .elect_mode(elect_mode),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      out_valid      <= 1'b0;
      elect_mode     <= VT_MIN;
      elected_valid  <= 1'b0;
      elected_value  <= 32'b0;
      elected_client <= NO_CLIENT;
      has_voted      <= 1'b0;
      forced_active  <= 1'b0;
      forced_value   <= 32'b0;
      p_valid        <= 1'b0;
      scan_cnt       <= '0;
    end else begin
      if (state == S_DONE && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_we) begin
        elect_mode <= cfg_data;
        if (!has_voted) begin
          elected_valid  <= (cfg_data == VT_ANY);
          elected_value  <= 32'b0;
          elected_client <= NO_CLIENT;
        end
      end
      p_valid <= issuing;
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            op_r       <= op;
            client_r   <= client;
            en_r       <= enabled;
            value_r    <= value;
            in_range_r <= in_range;
            idx_r      <= in_range ? client_ext[IDX_W-1:0] : '0;
            n_r        <= 1'b0;
            nh_r       <= 1'b0;
            nv_r       <= 32'b0;
            nc_r       <= NO_CLIENT;
            state      <= S_READ;
          end
        end
        S_READ: begin
          cur_en   <= vote_ok ? en_r : rdata.en;
          cur_val  <= vote_ok ? new_val : rdata.val;
          scan_cnt <= '0;
          state    <= (vote_ok && !(same && has_voted)) ? S_SCAN : S_DONE;
          case (op_r)
            OP_SET: begin
              n_r           <= 1'b1;
              nh_r          <= 1'b1;
              nv_r          <= value_r;
              nc_r          <= {1'b0, client_r};
              forced_active <= 1'b1;
              forced_value  <= value_r;
            end
            OP_CLR: begin
              n_r           <= 1'b1;
              nh_r          <= elected_valid;
              nv_r          <= elected_valid ? elected_value : 32'b0;
              nc_r          <= elected_client;
              forced_active <= 1'b0;
            end
            default: begin
            end
          endcase
        end
        S_SCAN: begin
          if (issuing) begin
            p_idx    <= scan_cnt[IDX_W-1:0];
            scan_cnt <= scan_cnt + 1'b1;
          end else if (!p_valid) begin
            state <= S_ELECT;
          end
        end
        S_ELECT: begin
          if (changed) begin
            elected_valid  <= res.ok;
            elected_value  <= res.val;
            elected_client <= who;
            if (!forced_active) begin
              n_r  <= 1'b1;
              nh_r <= res.ok;
              nv_r <= res.val;
              nc_r <= who;
            end
          end
          has_voted <= 1'b1;
          state     <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            notify             <= n_r;
            notify_has_value   <= nh_r;
            notify_value       <= nv_r;
            notify_client      <= nc_r;
            effective_valid    <= forced_active || elected_valid;
            effective_value    <= forced_active ? forced_value :
                                  (elected_valid ? elected_value : 32'b0);
            effective_client   <= elected_client;
            override_active    <= forced_active;
            client_enabled     <= in_range_r && cur_en;
            client_value_valid <= in_range_r && ((elect_mode == VT_ANY) || cur_en);
            client_value       <= (in_range_r && ((elect_mode == VT_ANY) || cur_en)) ?
                                  cur_val : 32'b0;
            state              <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_empty_elect: assert property (@(posedge clk) disable iff (rst)
    !elected_valid |-> (elected_value == 32'b0) && (elected_client == NO_CLIENT))
    else $error("empty elected result carries a value or client");

  a_elect_after_scan: assert property (@(posedge clk) disable iff (rst)
    (state == S_ELECT) |-> $past(state) == S_SCAN)
    else $error("election applied without a scan");

  a_vote_notify_no_override: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE) && n_r && (op_r == OP_VOTE) |-> !forced_active)
    else $error("vote notified while override active");

  a_no_value_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && notify && !notify_has_value |-> notify_value == 32'sd0)
    else $error("notify without value carries nonzero value");

endmodule

/* rtl/vagg_vote_mem.sv */
module vagg_vote_mem
  import vagg_pkg::*;
#(
  parameter int NUM_CLIENTS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           we,
  input  logic [$clog2(NUM_CLIENTS)-1:0] waddr,
  input  vote_t                          wdata,
  input  logic [$clog2(NUM_CLIENTS)-1:0] raddr,
  output vote_t                          rdata
);

  vote_t              mem [NUM_CLIENTS];
  logic [NUM_CLIENTS-1:0] vld;
  vote_t              data_q;
  logic               vld_q;

  // entries never written read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (we) begin
      vld[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    data_q <= mem[raddr];
    vld_q  <= vld[raddr];
  end

  assign rdata = vld_q ? data_q : '0;

endmodule

/* rtl/vagg_elect.sv */
module vagg_elect
  import vagg_pkg::*;
#(
  parameter int NUM_CLIENTS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           clear,
  input  logic                           ent_valid,
  input  vote_t                          ent,
  input  logic [$clog2(NUM_CLIENTS)-1:0] ent_idx,
  input  logic [1:0]                     elect_mode,
  output elect_t                         res
);

  localparam int IDX_W = $clog2(NUM_CLIENTS);

  logic             found;
  logic             any_en;
  logic [31:0]      best_val;
  logic [4:0]       best_who;
  logic             better;
  logic [IDX_W+4:0] who_ext;

  assign who_ext = {5'b0, ent_idx};

  always_comb begin
    if (!found) begin
      better = 1'b1;
    end else if (elect_mode == VT_MIN) begin
      better = $signed(ent.val) < $signed(best_val);
    end else begin
      better = $signed(ent.val) > $signed(best_val);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      found  <= 1'b0;
      any_en <= 1'b0;
    end else if (ent_valid && ent.en) begin
      any_en <= 1'b1;
      if (better) begin
        found    <= 1'b1;
        best_val <= ent.val;
        best_who <= who_ext[4:0];
      end
    end
  end

  // who in any mode is replaced by the voter upstream
  always_comb begin
    if (elect_mode == VT_ANY) begin
      res.ok  = 1'b1;
      res.val = {31'b0, any_en};
      res.who = NO_CLIENT;
    end else begin
      res.ok  = found;
      res.val = found ? best_val : 32'b0;
      res.who = found ? best_who : NO_CLIENT;
    end
  end

endmodule
